>>> hw/rtl/elsw_pkg.sv
// Shared types, constants and the quarter-sine table for the event leaky gate / sine warp core.
// No dependencies; every other file imports this package.
package elsw_pkg;

    localparam int BATCH_SIZE  = 4;
    localparam int REGION_ROWS = 7;
    localparam int REGION_COLS = 4;
    localparam int NCELL       = REGION_ROWS * REGION_COLS;
    localparam int CELL_W      = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int BATCH_W     = $clog2(BATCH_SIZE + 1);

    localparam logic [6:0] X_MAX   = 7'd125;
    localparam logic [6:0] Y_MAX   = 7'd111;
    localparam logic [7:0] CNT_MAX = 8'hFF;

    typedef enum logic [2:0] {
        CFG_WARM_STEP      = 3'd0,
        CFG_LEAK_SHIFT     = 3'd1,
        CFG_SPLAT_LEVEL    = 3'd2,
        CFG_REGION_MINIMUM = 3'd3,
        CFG_TIME_SHIFT     = 3'd4,
        CFG_SPACE_SHIFT    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [6:0]  pos_x;
        logic [6:0]  pos_y;
        logic [15:0] stamp;
        logic        polarity;
    } t_event;

    typedef struct packed {
        logic [6:0] warped_x;
        logic [6:0] warped_y;
        logic       last_polarity;
        logic [4:0] strength;
        logic       real_splat;
    } t_result;

    typedef struct packed {
        logic [7:0] warm_step;
        logic [2:0] leak_shift;
        logic [7:0] splat_level;
        logic [7:0] region_minimum;
        logic [3:0] time_shift;
        logic [2:0] space_shift;
    } t_cfg;

    typedef struct packed {
        logic       last;
        logic [4:0] strength;
        logic       real_splat;
    } t_act_status;

    function automatic logic [3:0] quarter_sine(input logic [5:0] idx);
        logic [3:0] mag;
        case (idx) inside
            [6'd0:6'd2]:   mag = 4'd0;
            [6'd3:6'd7]:   mag = 4'd1;
            [6'd8:6'd12]:  mag = 4'd2;
            [6'd13:6'd18]: mag = 4'd3;
            [6'd19:6'd24]: mag = 4'd4;
            [6'd25:6'd30]: mag = 4'd5;
            [6'd31:6'd38]: mag = 4'd6;
            [6'd39:6'd49]: mag = 4'd7;
            default:       mag = 4'd8;
        endcase
        return mag;
    endfunction

    // full-wave offset in [-8, 8] over a 256-step phase
    function automatic logic signed [4:0] sine_offset(input logic [7:0] phase);
        logic [5:0] pos;
        logic [4:0] mag;
        pos = phase[6] ? ~phase[5:0] : phase[5:0];
        mag = {1'b0, quarter_sine(pos)};
        return phase[7] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

>>> hw/rtl/elsw_cfg.sv
// Configuration register file of the event leaky gate / sine warp core.
// Depends on elsw_pkg.
module elsw_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    output elsw_pkg::t_cfg o_cfg
);
    import elsw_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warm_step      <= 8'd32;
            r_cfg.leak_shift     <= 3'd2;
            r_cfg.splat_level    <= 8'd64;
            r_cfg.region_minimum <= 8'd48;
            r_cfg.time_shift     <= 4'd8;
            r_cfg.space_shift    <= 3'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WARM_STEP:      r_cfg.warm_step      <= i_cfg_data;
                CFG_LEAK_SHIFT:     r_cfg.leak_shift     <= i_cfg_data[2:0];
                CFG_SPLAT_LEVEL:    r_cfg.splat_level    <= i_cfg_data;
                CFG_REGION_MINIMUM: r_cfg.region_minimum <= i_cfg_data;
                CFG_TIME_SHIFT:     r_cfg.time_shift     <= i_cfg_data[3:0];
                CFG_SPACE_SHIFT:    r_cfg.space_shift    <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

endmodule

>>> hw/rtl/elsw_act.sv
// Activity counters: global and per-region warm/leak, and the batch counter.
// Depends on elsw_pkg.
module elsw_act (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  elsw_pkg::t_cfg              i_cfg,
    input  logic                        i_fire,
    input  logic [elsw_pkg::CELL_W-1:0] i_cell,
    output elsw_pkg::t_act_status       o_status
);
    import elsw_pkg::*;

    function automatic logic [7:0] warm(input logic [7:0] c, input logic [7:0] step);
        logic [8:0] s;
        s = {1'b0, c} + {1'b0, step};
        return s[8] ? CNT_MAX : s[7:0];
    endfunction

    function automatic logic [7:0] leak(input logic [7:0] c, input logic [2:0] sh);
        return c - (c >> sh);
    endfunction

    logic [7:0]         r_global;
    logic [7:0]         r_region [NCELL];
    logic [BATCH_W-1:0] r_batch;

    logic [7:0]         n_global;
    logic [7:0]         n_region [NCELL];
    logic [BATCH_W-1:0] n_batch;
    logic [7:0]         sel_region [NCELL];
    logic [7:0]         warm_g, warm_c, leak_g, leak_c;
    logic               last;

    assign last   = (r_batch == BATCH_W'(BATCH_SIZE - 1));
    assign warm_g = warm(r_global, i_cfg.warm_step);
    assign warm_c = warm(r_region[i_cell], i_cfg.warm_step);
    assign leak_g = leak(warm_g, i_cfg.leak_shift);
    assign leak_c = leak(warm_c, i_cfg.leak_shift);

    assign n_global = last ? leak_g : warm_g;
    assign n_batch  = last ? '0 : BATCH_W'(r_batch + 1'b1);

    always_comb begin
        for (int i = 0; i < NCELL; i++) begin
            sel_region[i] = (CELL_W'(i) == i_cell) ? warm_c : r_region[i];
            n_region[i]   = last ? leak(sel_region[i], i_cfg.leak_shift) : sel_region[i];
        end
    end

    assign o_status.last       = last;
    assign o_status.strength   = leak_g[7:3];
    assign o_status.real_splat = (leak_g >= i_cfg.splat_level)
                              && (leak_c >= i_cfg.region_minimum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global <= '0;
            r_batch  <= '0;
            for (int i = 0; i < NCELL; i++) begin
                r_region[i] <= '0;
            end
        end else if (i_fire) begin
            r_global <= n_global;
            r_batch  <= n_batch;
            for (int i = 0; i < NCELL; i++) begin
                r_region[i] <= n_region[i];
            end
        end
    end

    a_batch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_batch < BATCH_W'(BATCH_SIZE))
        else $error("batch count out of range");

    a_batch_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && last |=> r_batch == '0)
        else $error("batch count did not wrap after a full batch");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_global) && $stable(r_batch))
        else $error("counters changed without an item");

endmodule

>>> hw/rtl/elsw_warp.sv
// Sine warp of one event: time/space phase, quarter-sine offset, clamp to the frame.
// Depends on elsw_pkg.
module elsw_warp (
    input  logic [6:0]  i_x,
    input  logic [6:0]  i_y,
    input  logic [15:0] i_stamp,
    input  logic [3:0]  i_time_shift,
    input  logic [2:0]  i_space_shift,
    output logic [6:0]  o_wx,
    output logic [6:0]  o_wy
);
    import elsw_pkg::*;

    function automatic logic [6:0] clamp_add(input logic [6:0] v, input logic signed [4:0] off,
                                             input logic [6:0] hi);
        logic signed [8:0] s;
        s = $signed({2'b00, v}) + 9'(off);
        if (s < 0) return 7'd0;
        if (s > $signed({2'b00, hi})) return hi;
        return s[6:0];
    endfunction

    logic [7:0]  ph;
    logic [7:0]  ph_x, ph_y;

    assign ph   = 8'(i_stamp >> i_time_shift);
    assign ph_x = ph + 8'({1'b0, i_y} >> i_space_shift);
    assign ph_y = ph + 8'({1'b0, i_x} >> i_space_shift);

    assign o_wx = clamp_add(i_x, sine_offset(ph_x), X_MAX);
    assign o_wy = clamp_add(i_y, sine_offset(ph_y), Y_MAX);

endmodule

>>> hw/rtl/event_leaky_gate_sine_warp_core.sv
// Event leaky gate / sine warp core: input register, counter update and warp, result register.
// The result register is loaded as the item that closes its batch leaves the input register.
// Throughput: one item per cycle; a batch-closing item waits only while the result register
// is full and not being taken.
// Reset (synchronous, active low): counters and batch count cleared, registers to defaults,
// pipeline empty. Depends on elsw_pkg, elsw_cfg, elsw_act, elsw_warp.
module event_leaky_gate_sine_warp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  elsw_pkg::t_event  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output elsw_pkg::t_result o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);
    import elsw_pkg::*;

    localparam logic [1:0] RX_LIM = 2'(REGION_COLS - 1);
    localparam logic [2:0] RY_LIM = 3'(REGION_ROWS - 1);

    typedef struct packed {
        logic [6:0]        x;
        logic [6:0]        y;
        logic [15:0]       stamp;
        logic              pol;
        logic [CELL_W-1:0] region;
    } t_stage;

    t_cfg        cfg;
    t_act_status status;
    t_stage      r_s1, n_s1;
    logic        r_s1_valid;
    logic        r_out_valid;
    t_result     r_out;
    logic        out_free, s1_fire;
    logic [6:0]  wx, wy;
    logic [1:0]  rx;
    logic [2:0]  ry;

    elsw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // clamp to the frame and locate the region
    always_comb begin
        n_s1.x      = (i_in_data.pos_x > X_MAX) ? X_MAX : i_in_data.pos_x;
        n_s1.y      = (i_in_data.pos_y > Y_MAX) ? Y_MAX : i_in_data.pos_y;
        n_s1.stamp  = i_in_data.stamp;
        n_s1.pol    = i_in_data.polarity;
        rx          = (n_s1.x[6:5] > RX_LIM) ? RX_LIM : n_s1.x[6:5];
        ry          = (n_s1.y[6:4] > RY_LIM) ? RY_LIM : n_s1.y[6:4];
        n_s1.region = CELL_W'(int'(ry) * REGION_COLS + int'(rx));
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && (!status.last || out_free);
    assign o_in_ready = !r_s1_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1 <= n_s1;
        end
    end

    elsw_act u_act (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (s1_fire),
        .i_cell   (r_s1.region),
        .o_status (status)
    );

    elsw_warp u_warp (
        .i_x           (r_s1.x),
        .i_y           (r_s1.y),
        .i_stamp       (r_s1.stamp),
        .i_time_shift  (cfg.time_shift),
        .i_space_shift (cfg.space_shift),
        .o_wx          (wx),
        .o_wy          (wy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && status.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && status.last) begin
            r_out.warped_x      <= wx;
            r_out.warped_y      <= wy;
            r_out.last_polarity <= r_s1.pol;
            r_out.strength      <= status.strength;
            r_out.real_splat    <= status.real_splat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && status.last |=> o_out_valid)
        else $error("batch-closing item gave no result");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_fire |=> r_s1_valid && $stable(r_s1))
        else $error("stalled item lost or changed");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !(s1_fire && status.last))
        else $error("pending result overwritten");

    a_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.warped_x <= X_MAX && o_out_data.warped_y <= Y_MAX)
        else $error("warped point outside the frame");

endmodule

>>> dv/tb.sv
// Testbench for event_leaky_gate_sine_warp_core: events go in under random idling, each batch
// result is checked against an in-bench model of the activity counters and the sine warp.
// Depends on elsw_pkg and the core RTL; reads no files.
module tb;
    import elsw_pkg::*;

    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SEGMENTS      = 10;
    localparam int SEGMENT_ITEMS = 130;

    localparam logic [3:0] SINE_Q [64] = '{
        4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3,
        4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
        4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
        4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8
    };

    localparam t_cfg_idx REG_ORDER [6] = '{
        CFG_WARM_STEP, CFG_LEAK_SHIFT, CFG_SPLAT_LEVEL,
        CFG_REGION_MINIMUM, CFG_TIME_SHIFT, CFG_SPACE_SHIFT
    };

    typedef logic [7:0] t_reg_bytes [6];

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_event     i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_result    o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    event_leaky_gate_sine_warp_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // model state
    t_cfg        cfg_shadow;
    logic [7:0]  global_level;
    logic [7:0]  region_level [NCELL];
    int unsigned events_in_batch;
    t_result     warp_results_due [$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic int sine_warp(input logic [7:0] phase);
        logic [5:0] idx;
        int mag;
        idx = phase[6] ? (phase[5:0] ^ 6'h3F) : phase[5:0];
        mag = int'(SINE_Q[idx]);
        return phase[7] ? -mag : mag;
    endfunction

    function automatic logic [6:0] clamp_coord(input int v, input logic [6:0] hi);
        if (v < 0) return 7'd0;
        if (v > int'(hi)) return hi;
        return 7'(v);
    endfunction

    function automatic logic [7:0] warm_up(input logic [7:0] c);
        logic [8:0] sum;
        sum = {1'b0, c} + {1'b0, cfg_shadow.warm_step};
        return sum[8] ? CNT_MAX : sum[7:0];
    endfunction

    function automatic logic [7:0] leak_down(input logic [7:0] c);
        return c - (c >> cfg_shadow.leak_shift);
    endfunction

    task automatic reset_model();
        cfg_shadow.warm_step      = 8'd32;
        cfg_shadow.leak_shift     = 3'd2;
        cfg_shadow.splat_level    = 8'd64;
        cfg_shadow.region_minimum = 8'd48;
        cfg_shadow.time_shift     = 4'd8;
        cfg_shadow.space_shift    = 3'd4;
        global_level = '0;
        foreach (region_level[i]) region_level[i] = '0;
        events_in_batch = 0;
    endtask

    task automatic model_reg_write(input logic [2:0] idx, input logic [7:0] data);
        case (idx)
            CFG_WARM_STEP:      cfg_shadow.warm_step      = data;
            CFG_LEAK_SHIFT:     cfg_shadow.leak_shift     = data[2:0];
            CFG_SPLAT_LEVEL:    cfg_shadow.splat_level    = data;
            CFG_REGION_MINIMUM: cfg_shadow.region_minimum = data;
            CFG_TIME_SHIFT:     cfg_shadow.time_shift     = data[3:0];
            CFG_SPACE_SHIFT:    cfg_shadow.space_shift    = data[2:0];
            default: ;
        endcase
    endtask

    task automatic gate_and_warp(input t_event ev);
        logic [6:0]  x, y;
        int          rx, ry, slot;
        logic [15:0] ph;
        logic [7:0]  phase_x, phase_y;
        t_result     res;
        x = (ev.pos_x > X_MAX) ? X_MAX : ev.pos_x;
        y = (ev.pos_y > Y_MAX) ? Y_MAX : ev.pos_y;
        rx = int'(x >> 5);
        ry = int'(y >> 4);
        if (rx > REGION_COLS - 1) rx = REGION_COLS - 1;
        if (ry > REGION_ROWS - 1) ry = REGION_ROWS - 1;
        slot = ry * REGION_COLS + rx;
        global_level = warm_up(global_level);
        region_level[slot] = warm_up(region_level[slot]);
        events_in_batch++;
        if (events_in_batch < BATCH_SIZE) return;
        events_in_batch = 0;
        global_level = leak_down(global_level);
        foreach (region_level[i]) region_level[i] = leak_down(region_level[i]);
        ph = ev.stamp >> cfg_shadow.time_shift;
        phase_x = ph[7:0] + 8'(y >> cfg_shadow.space_shift);
        phase_y = ph[7:0] + 8'(x >> cfg_shadow.space_shift);
        res.warped_x      = clamp_coord(int'(x) + sine_warp(phase_x), X_MAX);
        res.warped_y      = clamp_coord(int'(y) + sine_warp(phase_y), Y_MAX);
        res.last_polarity = ev.polarity;
        res.strength      = global_level[7:3];
        res.real_splat    = (global_level >= cfg_shadow.splat_level) &&
                            (region_level[slot] >= cfg_shadow.region_minimum);
        warp_results_due.push_back(res);
    endtask

    // receiver side
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (warp_results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, o_out_data);
                errors++;
            end else begin
                want = warp_results_due.pop_front();
                check_field("warped_x", want.warped_x, o_out_data.warped_x);
                check_field("warped_y", want.warped_y, o_out_data.warped_y);
                check_field("last_polarity", want.last_polarity, o_out_data.last_polarity);
                check_field("strength", want.strength, o_out_data.strength);
                check_field("real_splat", want.real_splat, o_out_data.real_splat);
            end
        end
    end

    task automatic send_event(input t_event ev);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        gate_and_warp(ev);
    endtask

    // leaves valid high; callers lower it once their writes are done
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        model_reg_write(idx, data);
    endtask

    task automatic apply_settings(input t_reg_bytes vals);
        foreach (REG_ORDER[i]) write_reg(REG_ORDER[i], vals[i]);
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending and wait until all batch results are back and the pipe is quiet
    task automatic settle();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (warp_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_event make_event(input int x, input int y, input int stamp,
                                          input int pol);
        t_event ev;
        ev.pos_x    = 7'(x);
        ev.pos_y    = 7'(y);
        ev.stamp    = 16'(stamp);
        ev.polarity = 1'(pol);
        return ev;
    endfunction

    task automatic test_corner_events();
        // first batch stays in one region so the splat flag comes up under defaults
        send_event(make_event(0, 0, 16'h0000, 0));
        send_event(make_event(5, 3, 16'h0100, 1));
        send_event(make_event(31, 15, 16'h3F00, 0));
        send_event(make_event(0, 0, 16'h4000, 1));
        // frame clamp on both axes, all ones
        send_event(make_event(127, 127, 16'hFFFF, 1));
        send_event(make_event(126, 112, 16'h8000, 0));
        send_event(make_event(125, 111, 16'hC000, 1));
        send_event(make_event(127, 0, 16'h7F00, 0));
        send_event(make_event(0, 127, 16'hBF00, 1));
        send_event(make_event(64, 48, 16'h0040, 0));
        send_event(make_event(96, 96, 16'h2000, 1));
        send_event(make_event(0, 112, 16'hFFFF, 0));
        send_event(make_event(32, 16, 16'h6000, 1));
        send_event(make_event(33, 17, 16'hA000, 0));
        send_event(make_event(34, 18, 16'hE000, 1));
        send_event(make_event(35, 19, 16'h5555, 0));
        settle();
    endtask

    task automatic test_register_edges();
        t_reg_bytes vals;
        // unused indexes must not disturb the live settings
        write_reg(CFG_SPARE_A, 8'hFF);
        write_reg(CFG_SPARE_B, 8'h00);
        // oversized data is cut to the register width; space shift 7 is legal
        write_reg(CFG_SPACE_SHIFT, 8'hFF);
        write_reg(CFG_TIME_SHIFT, 8'hF1);
        write_reg(CFG_LEAK_SHIFT, 8'hF8);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_event(make_event(120, 100, 16'hFFFF, 1));
        send_event(make_event(10, 110, 16'h1234, 0));
        send_event(make_event(127, 127, 16'h8765, 1));
        send_event(make_event(60, 2, 16'hFEDC, 0));
        settle();
        vals = '{8'd32, 8'd2, 8'd64, 8'd48, 8'd8, 8'd4};
        apply_settings(vals);
        @(posedge i_clk);
    endtask

    task automatic test_random_traffic();
        t_reg_bytes vals;
        t_event     ev;
        int         hot_x, hot_y;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 0) begin
                vals = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
            end else if (seg == 1) begin
                vals = '{8'd255, 8'd7, 8'd255, 8'd255, 8'd15, 8'd7};
            end else begin
                foreach (vals[i]) vals[i] = 8'($urandom);
                // keep most thresholds reachable
                if ($urandom_range(0, 3) != 0) begin
                    vals[CFG_SPLAT_LEVEL] = 8'($urandom_range(0, 160));
                end
                if ($urandom_range(0, 3) != 0) begin
                    vals[CFG_REGION_MINIMUM] = 8'($urandom_range(0, 160));
                end
            end
            apply_settings(vals);
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            @(posedge i_clk);
            hot_x = $urandom_range(0, 127);
            hot_y = $urandom_range(0, 127);
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                if ($urandom_range(0, 39) == 0) begin
                    hot_x = $urandom_range(0, 127);
                    hot_y = $urandom_range(0, 127);
                end
                ev.stamp    = 16'($urandom);
                ev.polarity = 1'($urandom);
                if ($urandom_range(0, 99) < 70) begin
                    ev.pos_x = 7'(hot_x + $urandom_range(0, 15));
                    ev.pos_y = 7'(hot_y + $urandom_range(0, 15));
                end else begin
                    ev.pos_x = 7'($urandom_range(0, 127));
                    ev.pos_y = 7'($urandom_range(0, 127));
                end
                send_event(ev);
            end
            settle();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_events();
        test_register_edges();
        test_random_traffic();
        settle();
        if (warp_results_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, warp_results_due.size());
            errors++;
        end
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/elsw_pkg.sv
hw/rtl/elsw_cfg.sv
hw/rtl/elsw_act.sv
hw/rtl/elsw_warp.sv
hw/rtl/event_leaky_gate_sine_warp_core.sv
dv/tb.sv
